FILE: sv/meu_pkg.sv
// Package: shared types and constants of the modular exponentiation core.
`timescale 1ns / 1ps
package meu_pkg;

  // Modulus after reset.
  localparam logic [63:0] DEFAULT_MODULUS = 64'd1000000007;

  // Opcodes of an input transaction.
  localparam logic OP_POWER   = 1'b0;
  localparam logic OP_INVERSE = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,    // wait for a transaction
    ST_REDUCE,  // reduce the base by the modulus, one bit a cycle
    ST_NEXT,    // pick the next product or finish
    ST_DBL,     // product: double the partial sum
    ST_ADD,     // product: add the multiplicand
    ST_WB,      // write the product back
    ST_DONE     // hand the residue to the output register
  } state_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic in_fire;     // input transaction taken this cycle
    logic zero_start;  // effective exponent zero or modulus zero
    logic exp_zero;    // no exponent bits left
    logic mul_bit;     // current multiplier bit
    logic out_free;    // output register can take a residue
  } status_t;

  // Sequencer controls to the datapath.
  typedef struct packed {
    state_t st;
    logic   last;      // last bit of the current pass
  } ctrl_t;

endpackage

FILE: sv/meu_req_if.sv
// Interface: request channel carrying opcode, base and exponent.
`timescale 1ns / 1ps
interface meu_req_if #(
  parameter int OPERAND_BITS = 31
);
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic [OPERAND_BITS-1:0] base;
  logic [OPERAND_BITS-1:0] exponent;

  modport source (output valid, output opcode, output base, output exponent, input ready);
  modport sink   (input valid, input opcode, input base, input exponent, output ready);
endinterface

FILE: sv/meu_rsp_if.sv
// Interface: response channel carrying the residue.
`timescale 1ns / 1ps
interface meu_rsp_if #(
  parameter int OPERAND_BITS = 31
);
  logic                    valid;
  logic                    ready;
  logic [OPERAND_BITS-1:0] residue;

  modport source (output valid, output residue, input ready);
  modport sink   (input valid, input residue, output ready);
endinterface

FILE: sv/modular_exponentiation_core.sv
// Top level: modular exponentiation core with request and response channels.
// Computes base^exponent mod modulus (opcode 0) or the Fermat inverse
// base^(modulus-2) mod modulus (opcode 1, meaningful for a prime modulus) by
// right-to-left square-and-multiply. An exponent of zero returns 1 and a
// modulus of zero with a nonzero exponent returns 0. Otherwise a transaction
// first reduces the base by the modulus bit by bit, then for each exponent
// bit up to the highest set one performs up to two modular products. All of
// this runs one step a cycle through a single shared modular add-and-subtract
// unit; the request channel is not ready while a transaction is in progress.
// The modulus register is written with cfg_we/cfg_wdata and must only change
// while the core is idle.
`timescale 1ns / 1ps
module modular_exponentiation_core #(
  parameter int OPERAND_BITS = 31
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [OPERAND_BITS-1:0] cfg_wdata,
  meu_req_if.sink                 req,
  meu_rsp_if.source               rsp
);
  localparam int W = OPERAND_BITS;

  logic [W-1:0] modulus;
  logic [W-1:0] exp_r;     // remaining exponent bits
  logic [W-1:0] b_sh;      // multiplier bits, MSB first
  logic [W-1:0] mcand;     // multiplicand of the current product
  logic [W-1:0] acc;       // running result
  logic [W-1:0] pw;        // current power of the base
  logic [W-1:0] r;         // partial sum / work value
  logic         phase;     // 0: multiply step pending, 1: square next
  logic         tgt_sq;    // product goes to pw
  logic         out_valid;
  logic [W-1:0] out_res;

  logic [W-1:0]    eff_exp;
  logic            in_fire;
  logic            out_free;
  logic            do_mul;
  logic [W:0]      unit_in;
  logic [W-1:0]    unit_out;
  meu_pkg::status_t status;
  meu_pkg::ctrl_t   ctrl;

  assign in_fire  = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign req.ready = (ctrl.st == meu_pkg::ST_IDLE);
  assign rsp.valid   = out_valid;
  assign rsp.residue = out_res;
  assign do_mul = !phase && exp_r[0];

  // Effective exponent: inverse uses modulus - 2, clamped at zero
  always_comb begin
    if (req.opcode == meu_pkg::OP_INVERSE) begin
      eff_exp = (modulus >= W'(2)) ? modulus - W'(2) : '0;
    end else begin
      eff_exp = req.exponent;
    end
  end

  assign status.in_fire    = in_fire;
  assign status.zero_start = (eff_exp == '0) || (modulus == '0);
  assign status.exp_zero   = (exp_r == '0);
  assign status.mul_bit    = b_sh[W-1];
  assign status.out_free   = out_free;

  // Operand select for the shared unit
  always_comb begin
    case (ctrl.st)
      meu_pkg::ST_REDUCE: unit_in = {r, b_sh[W-1]};
      meu_pkg::ST_DBL:    unit_in = {r, 1'b0};
      meu_pkg::ST_ADD:    unit_in = {1'b0, r} + {1'b0, mcand};
      default:            unit_in = {1'b0, r};
    endcase
  end

  meu_modadd #(.OPERAND_BITS(W)) u_modadd (
    .sum     (unit_in),
    .modulus (modulus),
    .result  (unit_out)
  );

  meu_seq #(.OPERAND_BITS(W)) u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // Modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= meu_pkg::DEFAULT_MODULUS[W-1:0];
    end else if (cfg_we) begin
      modulus <= cfg_wdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.st == meu_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.st == meu_pkg::ST_DONE && out_free) begin
      out_res <= r;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (ctrl.st)
      meu_pkg::ST_IDLE: begin
        if (in_fire) begin
          b_sh  <= req.base;
          exp_r <= eff_exp;
          r     <= (eff_exp == '0) ? W'(1) : '0;
        end
      end
      meu_pkg::ST_REDUCE: begin
        r    <= unit_out;
        b_sh <= b_sh << 1;
        if (ctrl.last) begin
          pw    <= unit_out;
          acc   <= (modulus == W'(1)) ? '0 : W'(1);
          phase <= 1'b0;
        end
      end
      meu_pkg::ST_NEXT: begin
        if (exp_r == '0) begin
          r <= acc;
        end else begin
          mcand  <= pw;
          b_sh   <= do_mul ? acc : pw;
          tgt_sq <= !do_mul;
          r      <= '0;
        end
      end
      meu_pkg::ST_DBL: begin
        r <= unit_out;
        if (!b_sh[W-1]) b_sh <= b_sh << 1;
      end
      meu_pkg::ST_ADD: begin
        r    <= unit_out;
        b_sh <= b_sh << 1;
      end
      meu_pkg::ST_WB: begin
        if (tgt_sq) begin
          pw    <= r;
          exp_r <= exp_r >> 1;
          phase <= 1'b0;
        end else begin
          acc   <= r;
          phase <= 1'b1;
        end
      end
      default: begin
        r <= r;
      end
    endcase
  end
endmodule

FILE: sv/meu_modadd.sv
// Shared modular add unit: reduces a value below twice the modulus.
`timescale 1ns / 1ps
module meu_modadd #(
  parameter int OPERAND_BITS = 31
) (
  input  logic [OPERAND_BITS:0]   sum,
  input  logic [OPERAND_BITS-1:0] modulus,
  output logic [OPERAND_BITS-1:0] result
);
  logic [OPERAND_BITS:0] diff;
  logic                  ge;

  // Compare and subtract once
  always_comb begin
    ge   = sum >= {1'b0, modulus};
    diff = sum - {1'b0, modulus};
    result = ge ? diff[OPERAND_BITS-1:0] : sum[OPERAND_BITS-1:0];
  end
endmodule

FILE: sv/meu_seq.sv
// Sequencer: state machine and bit counter of the exponentiation core.
`timescale 1ns / 1ps
module meu_seq #(
  parameter int OPERAND_BITS = 31
) (
  input  logic             clk,
  input  logic             rst,
  input  meu_pkg::status_t status,
  output meu_pkg::ctrl_t   ctrl
);
  localparam int CW = $clog2(OPERAND_BITS);

  meu_pkg::state_t state, state_next;
  logic [CW-1:0]   cnt, cnt_next;
  logic            last;

  assign last = (cnt == '0);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      meu_pkg::ST_IDLE: begin
        if (status.in_fire) begin
          state_next = status.zero_start ? meu_pkg::ST_DONE : meu_pkg::ST_REDUCE;
        end
      end
      meu_pkg::ST_REDUCE: begin
        if (last) state_next = meu_pkg::ST_NEXT;
      end
      meu_pkg::ST_NEXT: begin
        state_next = status.exp_zero ? meu_pkg::ST_DONE : meu_pkg::ST_DBL;
      end
      meu_pkg::ST_DBL: begin
        if (status.mul_bit) state_next = meu_pkg::ST_ADD;
        else if (last) state_next = meu_pkg::ST_WB;
      end
      meu_pkg::ST_ADD: begin
        state_next = last ? meu_pkg::ST_WB : meu_pkg::ST_DBL;
      end
      meu_pkg::ST_WB: begin
        state_next = meu_pkg::ST_NEXT;
      end
      meu_pkg::ST_DONE: begin
        if (status.out_free) state_next = meu_pkg::ST_IDLE;
      end
      default: state_next = meu_pkg::ST_IDLE;
    endcase
  end

  // Bit counter: load per pass, count down per finished bit
  always_comb begin
    cnt_next = cnt;
    case (state)
      meu_pkg::ST_IDLE:   cnt_next = CW'(OPERAND_BITS - 1);
      meu_pkg::ST_NEXT:   cnt_next = CW'(OPERAND_BITS - 1);
      meu_pkg::ST_REDUCE: if (!last) cnt_next = cnt - 1'b1;
      meu_pkg::ST_DBL:    if (!status.mul_bit && !last) cnt_next = cnt - 1'b1;
      meu_pkg::ST_ADD:    if (!last) cnt_next = cnt - 1'b1;
      default:            cnt_next = cnt;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl.st   = state;
    ctrl.last = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= meu_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end
endmodule

FILE: sv/meu_checker.sv
// Checker: port-level properties of the exponentiation core, bound to the top.
`timescale 1ns / 1ps
module meu_checker #(
  parameter int OPERAND_BITS = 31
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [OPERAND_BITS-1:0] residue
);
  // Busy right after a transaction is taken
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while a transaction is in progress");

  // A residue appears only while the request side is busy
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("residue without a transaction in progress");

  // No residue in the cycle right after a request is taken
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("residue too early after request");

  // Stalled response holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(residue)))
    else $error("stalled residue dropped or changed");
endmodule

bind modular_exponentiation_core meu_checker #(.OPERAND_BITS(OPERAND_BITS)) u_meu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .residue   (rsp.residue)
);
